>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LSH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LSH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/lsh_pkg.sv
// ----------------------------------------------------------------------------
// lsh_pkg
// Types and constants of the link setup handshake.
// ----------------------------------------------------------------------------
package lsh_pkg;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WAIT  = 2'd1,
    PH_CONN  = 2'd2,
    PH_ABORT = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_ROLE    = 2'd0,
    REG_MAX_ATT = 2'd1,
    REG_TIMEOUT = 2'd2,
    REG_UNUSED  = 2'd3
  } cfg_reg_t;

  localparam logic [7:0] FLAG_BYTE  = 8'h7e;
  localparam logic [7:0] ADDR_BYTE  = 8'h03;
  localparam logic [7:0] CTRL_BYTE  = 8'h03;
  localparam logic [7:0] CHECK_BYTE = ADDR_BYTE ^ CTRL_BYTE;

  localparam int unsigned FRAME_LEN = 5;
  localparam int unsigned IDX_W     = $clog2(FRAME_LEN);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_LEN - 1);

  // Matcher positions
  localparam logic [2:0] MS_HUNT  = 3'd0;
  localparam logic [2:0] MS_ADDR  = 3'd1;
  localparam logic [2:0] MS_CTRL  = 3'd2;
  localparam logic [2:0] MS_CHECK = 3'd3;
  localparam logic [2:0] MS_CLOSE = 3'd4;

  typedef logic [IDX_W-1:0] idx_t;

  function automatic logic [7:0] frame_byte(input idx_t idx);
    logic [7:0] b;
    unique case (idx)
      IDX_W'(0): b = FLAG_BYTE;
      IDX_W'(1): b = ADDR_BYTE;
      IDX_W'(2): b = CTRL_BYTE;
      IDX_W'(3): b = CHECK_BYTE;
      default:   b = FLAG_BYTE;
    endcase
    return b;
  endfunction

endpackage

>>> hdl/lsh_in_if.sv
// ----------------------------------------------------------------------------
// lsh_in_if
// Input item channel: start, received byte or tick.
// ----------------------------------------------------------------------------
interface lsh_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] rx_byte;

  modport source (output valid, operation, rx_byte, input ready);
  modport sink   (input valid, operation, rx_byte, output ready);
endinterface

>>> hdl/lsh_out_if.sv
// ----------------------------------------------------------------------------
// lsh_out_if
// Result item channel: frame byte or status report.
// ----------------------------------------------------------------------------
interface lsh_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       last;
  logic [1:0] link_status;

  modport source (output valid, tx_valid, tx_byte, last, link_status, input ready);
  modport sink   (input valid, tx_valid, tx_byte, last, link_status, output ready);
endinterface

>>> hdl/link_setup_handshake.sv
// ----------------------------------------------------------------------------
// link_setup_handshake
// SET/reply link establishment: matcher, attempt timer and frame emitter.
// ----------------------------------------------------------------------------
// An item updates the link state at the accepting edge; its first result
//   passes through the descriptor register and then the emitter register.
// The block takes 1 item per cycle while out_chan.ready is high and the item
//   yields a status result; a SET/reply frame holds the emitter for its 5 bytes, one byte per cycle while ready.
// Reset (rst_n low, synchronous): phase idle, counters and matcher cleared,
//   role receiver, 3 attempts, 3 ticks; both result registers empty.
`include "assert_macros.svh"

module link_setup_handshake (
  input  logic     clk,
  input  logic     rst_n,
  lsh_in_if.sink   in_chan,
  lsh_out_if.source out_chan,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);
  import lsh_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic       role_r;
  logic [7:0] max_att_r;
  logic [7:0] timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      role_r    <= 1'b0;
      max_att_r <= 8'd3;
      timeout_r <= 8'd3;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROLE:    role_r    <= cfg_wdata[0];
        REG_MAX_ATT: max_att_r <= cfg_wdata;
        REG_TIMEOUT: timeout_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Link state
  // --------------------------------------------------------------------------
  phase_t     phase_r,   phase_nxt;
  logic [2:0] match_r,   match_nxt;
  logic [7:0] attempt_r, attempt_nxt;
  logic [7:0] tick_r,    tick_nxt;
  logic       ffp_r,     ffp_nxt;   // first flag of attempt not yet seen
  logic       send_frame;           // item answers with a full frame

  logic in_acc;
  logic start_acc;
  op_t  op;
  logic [7:0] rxb;
  logic [7:0] limit;
  logic [7:0] tick_inc;
  logic [7:0] att_inc;

  assign op  = op_t'(in_chan.operation);
  assign rxb = in_chan.rx_byte;

  // Zero timeout behaves as one tick.
  assign limit    = (timeout_r == 8'd0) ? 8'd1 : timeout_r;
  assign tick_inc = (tick_r == 8'hff) ? tick_r : tick_r + 8'd1;
  assign att_inc  = (attempt_r == 8'hff) ? attempt_r : attempt_r + 8'd1;

  always_comb begin
    phase_nxt   = phase_r;
    match_nxt   = match_r;
    attempt_nxt = attempt_r;
    tick_nxt    = tick_r;
    ffp_nxt     = ffp_r;
    send_frame  = 1'b0;

    if (op == OP_START) begin
      // Start always restarts from scratch.
      match_nxt   = MS_HUNT;
      attempt_nxt = 8'd0;
      tick_nxt    = 8'd0;
      ffp_nxt     = 1'b1;
      if (max_att_r == 8'd0) begin
        phase_nxt = PH_ABORT;
      end else begin
        phase_nxt  = PH_WAIT;
        send_frame = role_r;
      end
    end else if (phase_r == PH_WAIT) begin
      unique case (op)
        OP_BYTE: begin
          unique case (match_r)
            MS_HUNT: begin
              if (rxb == FLAG_BYTE) begin
                // Receiver restarts its timer on the first flag of an attempt.
                if (!role_r && ffp_r) begin
                  tick_nxt = 8'd0;
                  ffp_nxt  = 1'b0;
                end
                match_nxt = MS_ADDR;
              end
            end
            MS_ADDR: begin
              if (rxb == ADDR_BYTE)      match_nxt = MS_CTRL;
              else if (rxb != FLAG_BYTE) match_nxt = MS_HUNT;
            end
            MS_CTRL: begin
              if (rxb == CTRL_BYTE)      match_nxt = MS_CHECK;
              else if (rxb == FLAG_BYTE) match_nxt = MS_ADDR;
              else                       match_nxt = MS_HUNT;
            end
            MS_CHECK: begin
              if (rxb == CHECK_BYTE)     match_nxt = MS_CLOSE;
              else if (rxb == FLAG_BYTE) match_nxt = MS_ADDR;
              else                       match_nxt = MS_HUNT;
            end
            MS_CLOSE: begin
              match_nxt = MS_HUNT;
              // Closing flag completes the frame.
              if (rxb == FLAG_BYTE) begin
                phase_nxt  = PH_CONN;
                send_frame = !role_r;
              end
            end
            default: match_nxt = MS_HUNT;
          endcase
        end
        OP_TICK: begin
          tick_nxt = tick_inc;
          if (tick_inc >= limit) begin
            attempt_nxt = att_inc;
            if (att_inc >= max_att_r) begin
              phase_nxt = PH_ABORT;
            end else begin
              // Next attempt: timer restarts, transmitter resends SET.
              tick_nxt   = 8'd0;
              ffp_nxt    = 1'b1;
              send_frame = role_r;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      match_r   <= MS_HUNT;
      attempt_r <= 8'd0;
      tick_r    <= 8'd0;
      ffp_r     <= 1'b1;
    end else if (in_acc) begin
      phase_r   <= phase_nxt;
      match_r   <= match_nxt;
      attempt_r <= attempt_nxt;
      tick_r    <= tick_nxt;
      ffp_r     <= ffp_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result descriptor register: frame or status, plus status after the item
  // --------------------------------------------------------------------------
  logic   desc_valid_r;
  logic   desc_frame_r;
  phase_t desc_status_r;
  logic   load;

  assign in_chan.ready = !desc_valid_r || load;
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign start_acc     = in_acc && (op == OP_START);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_valid_r <= 1'b0;
    end else if (in_acc) begin
      desc_valid_r <= 1'b1;
    end else if (load) begin
      desc_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      desc_frame_r  <= send_frame;
      desc_status_r <= phase_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Emitter: walks the 5 frame bytes, or shows one status result
  // --------------------------------------------------------------------------
  logic   out_valid_r;
  logic   out_frame_r;
  phase_t out_status_r;
  idx_t   idx_r;
  logic   out_acc;
  logic   out_last;

  assign out_last = !out_frame_r || (idx_r == IDX_LAST);
  assign out_acc  = out_valid_r && out_chan.ready;
  assign load     = desc_valid_r && (!out_valid_r || (out_acc && out_last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      idx_r       <= '0;
    end else if (out_acc) begin
      if (out_last) begin
        out_valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + idx_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_frame_r  <= desc_frame_r;
      out_status_r <= desc_status_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.tx_valid    = out_frame_r;
  assign out_chan.tx_byte     = out_frame_r ? frame_byte(idx_r) : 8'd0;
  assign out_chan.last        = out_last;
  assign out_chan.link_status = out_status_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `LSH_ASSERT_NOW(a_idx_range, out_valid_r, idx_r <= IDX_LAST, "frame index out of range")
  `LSH_ASSERT_NOW(a_idx_frame, out_valid_r && (idx_r != '0), out_frame_r, "index moved")
  `LSH_ASSERT_NEXT(a_desc_hold, desc_valid_r && !load && !in_acc, desc_valid_r, "desc lost")
  `LSH_ASSERT_NEXT(a_start_wait, start_acc && (max_att_r != '0), phase_r == PH_WAIT, "no wait")
  `LSH_ASSERT_NEXT(a_conn_hold, (phase_r == PH_CONN) && !start_acc, phase_r == PH_CONN, "left")

endmodule
